@@ rtl/core/wsm_pkg.sv @@
// Shared constants, command codes and control types for the wildcard star matcher.
package wsm_pkg;

  // Element store capacity.
  localparam int MAX_ELEMENTS = 16;

  // Number of positions: one per element plus the final accepting position.
  localparam int POS_N = MAX_ELEMENTS + 1;

  // Width of an element count that can also hold the capacity itself.
  localparam int CNT_W = $clog2(POS_N);

  // Width of an index into the element store.
  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  // Pattern bytes with a special meaning.
  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] DOT_BYTE  = 8'h2E;

  // Input item commands.
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_FEED   = 2'd1,
    CMD_END    = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // Per-cycle operation strobes from the controller to the datapath.
  typedef struct packed {
    logic do_append;
    logic do_feed;
    logic do_report;
    logic do_clear;
  } dp_ctl_t;

endpackage

@@ rtl/core/wsm_ifs.sv @@
// Valid/ready channel interfaces for the matcher's input and result items.

interface wsm_in_if;
  logic             valid;
  logic             ready;
  wsm_pkg::cmd_t    command;
  logic [7:0]       char_value;

  modport source (output valid, output command, output char_value, input ready);
  modport sink   (input valid, input command, input char_value, output ready);
endinterface

interface wsm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

@@ rtl/core/wsm_ctrl.sv @@
// Controller: handshake state machine and command decode for the matcher.
module wsm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  wsm_pkg::cmd_t      in_command,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output wsm_pkg::dp_ctl_t   dp_ctl
);
  import wsm_pkg::*;

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;
  logic   is_report;

  // A new item may enter unless a result is waiting and is not taken this cycle.
  assign in_ready  = (state_r == ST_EMPTY) || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = (state_r == ST_FULL);

  // Decode the accepted command into datapath strobes.
  always_comb begin
    dp_ctl = '0;
    if (accept) begin
      unique case (in_command)
        CMD_APPEND: dp_ctl.do_append = 1'b1;
        CMD_FEED:   dp_ctl.do_feed   = 1'b1;
        CMD_END:    dp_ctl.do_report = 1'b1;
        CMD_CLEAR:  dp_ctl.do_clear  = 1'b1;
        default:    dp_ctl = '0;
      endcase
    end
  end

  assign is_report = dp_ctl.do_report;

  // Result slot occupancy.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EMPTY: begin
        if (is_report) state_nxt = ST_FULL;
      end
      ST_FULL: begin
        if (out_ready && !is_report) state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/wsm_datapath.sv @@
// Datapath: element store, active position set with star closure, result registers.
module wsm_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  wsm_pkg::dp_ctl_t   dp_ctl,
  input  logic [7:0]         char_value,
  output logic               matched,
  output logic               pattern_overflow
);
  import wsm_pkg::*;

  logic [7:0]        elem_byte_r [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] elem_star_r;
  logic [MAX_ELEMENTS-1:0] elem_star_nxt;
  logic [CNT_W-1:0]  elem_cnt_r;
  logic [CNT_W-1:0]  elem_cnt_nxt;
  logic              ovf_r;
  logic              ovf_nxt;
  logic [POS_N-1:0]  raw_r;
  logic [POS_N-1:0]  raw_nxt;
  logic              matched_r;
  logic              ovf_out_r;

  logic [POS_N-1:0]        closed;
  logic [MAX_ELEMENTS-1:0] elem_valid;
  logic [MAX_ELEMENTS-1:0] hit;
  logic [POS_N-1:0]        stepped;
  logic [IDX_W-1:0]        last_idx;
  logic [IDX_W-1:0]        wr_idx;
  logic                    star_prev;
  logic                    store_full;
  logic                    write_elem;

  // Close the raw set over starred elements: a starred element may be skipped.
  always_comb begin
    closed[0] = raw_r[0];
    for (int p = 0; p < MAX_ELEMENTS; p++) begin
      closed[p+1] = raw_r[p+1] | (closed[p] & elem_star_r[p]);
    end
  end

  // One text byte: each live element that accepts it either stays (starred) or advances.
  always_comb begin
    for (int p = 0; p < MAX_ELEMENTS; p++) begin
      elem_valid[p] = (CNT_W'(p) < elem_cnt_r);
      hit[p] = closed[p] && elem_valid[p] &&
               ((elem_byte_r[p] == DOT_BYTE) || (elem_byte_r[p] == char_value));
    end
    stepped[0] = hit[0] & elem_star_r[0];
    for (int p = 1; p < MAX_ELEMENTS; p++) begin
      stepped[p] = (hit[p] & elem_star_r[p]) | (hit[p-1] & ~elem_star_r[p-1]);
    end
    stepped[MAX_ELEMENTS] = hit[MAX_ELEMENTS-1] & ~elem_star_r[MAX_ELEMENTS-1];
  end

  // Pattern append decisions.
  assign last_idx   = IDX_W'(elem_cnt_r - CNT_W'(1));
  assign wr_idx     = elem_cnt_r[IDX_W-1:0];
  assign star_prev  = (char_value == STAR_BYTE) && (elem_cnt_r != '0) &&
                      !elem_star_r[last_idx];
  assign store_full = (elem_cnt_r == CNT_W'(MAX_ELEMENTS));
  assign write_elem = dp_ctl.do_append && !ovf_r && !star_prev && !store_full;

  // Next state of the pattern store and the active set.
  always_comb begin
    elem_star_nxt = elem_star_r;
    elem_cnt_nxt  = elem_cnt_r;
    ovf_nxt       = ovf_r;
    raw_nxt       = raw_r;
    if (dp_ctl.do_append) begin
      if (!ovf_r) begin
        if (star_prev) begin
          elem_star_nxt[last_idx] = 1'b1;
        end else if (store_full) begin
          ovf_nxt = 1'b1;
        end else begin
          elem_star_nxt[wr_idx] = 1'b0;
          elem_cnt_nxt = elem_cnt_r + CNT_W'(1);
        end
      end
      raw_nxt = POS_N'(1);
    end
    if (dp_ctl.do_feed) begin
      raw_nxt = stepped;
    end
    if (dp_ctl.do_report) begin
      raw_nxt = POS_N'(1);
    end
    if (dp_ctl.do_clear) begin
      elem_star_nxt = '0;
      elem_cnt_nxt  = '0;
      ovf_nxt       = 1'b0;
      raw_nxt       = POS_N'(1);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_star_r <= '0;
      elem_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      raw_r       <= POS_N'(1);
    end else begin
      elem_star_r <= elem_star_nxt;
      elem_cnt_r  <= elem_cnt_nxt;
      ovf_r       <= ovf_nxt;
      raw_r       <= raw_nxt;
    end
  end

  // Element bytes and result payload need no reset.
  always_ff @(posedge clk) begin
    if (write_elem) begin
      elem_byte_r[wr_idx] <= char_value;
    end
    if (dp_ctl.do_report) begin
      matched_r <= closed[elem_cnt_r];
      ovf_out_r <= ovf_r;
    end
  end

  assign matched          = matched_r;
  assign pattern_overflow = ovf_out_r;

endmodule

@@ rtl/core/wildcard_star_regex_matcher_unit.sv @@
// Latency: an end-of-text item shows its result in the cycle after it is accepted.
// Throughput: one item per cycle while the input is ready; a text byte updates every
// position together through the combinational star closure chain across all elements.
// An item is held off only while a result waits and the result side is not ready.
// Reset (synchronous, active low) empties the pattern, clears the overflow flag,
// arms position zero and drops any pending result.
module wildcard_star_regex_matcher_unit (
  input  logic       clk,
  input  logic       rst_n,
  wsm_in_if.sink     in_chan,
  wsm_out_if.source  out_chan
);
  import wsm_pkg::*;

  dp_ctl_t dp_ctl;

  // Handshake and command decode.
  wsm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.command),
    .in_ready   (in_chan.ready),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .dp_ctl     (dp_ctl)
  );

  // Pattern store, active set and result registers.
  wsm_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .dp_ctl           (dp_ctl),
    .char_value       (in_chan.char_value),
    .matched          (out_chan.matched),
    .pattern_overflow (out_chan.pattern_overflow)
  );

endmodule
